// ----- hw/rtl/blind_motor_limit_controller_unit_macros.svh -----
// Assertion macros used by the blind controller state machine.
`ifndef BLIND_MOTOR_LIMIT_CONTROLLER_UNIT_MACROS_SVH
`define BLIND_MOTOR_LIMIT_CONTROLLER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMLC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BMLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bmlc_pkg.sv -----
// Shared types and constants of the blind motor limit controller.
`default_nettype none

package bmlc_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int STEPS_W    = 24;
    localparam int CNT16_W    = 16;
    localparam int AVG_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_STANDARD_STEPS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_STEPS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_THR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_THR        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_MARGIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_MARGIN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_PRESENT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_COUNT      = 3'd7;

    // Input word kinds
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_MEAS,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic in_load;
        logic start;
        logic accum;
        logic meas;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd_is_start;
        logic moving;
        logic start_emits;
        logic sample_ok;
        logic grp_full;
        logic div_done;
        logic meas_emits;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- hw/rtl/blind_motor_limit_controller_unit.sv -----
// Top level of the blind motor limit controller.
//
// Input stream (s_axis): tuser selects the word kind, 0 starts a move and
// 1 carries a light-sensor sample; tdata holds sample, learn and progressive
// flags. Output stream (m_axis): one word per step burst request, tlast on
// the burst that ends the move. Configuration is a plain write port.
// The block handles one input word at a time. A start that emits nothing,
// or a sample that does not complete an averaging group, passes only through
// the idle and evaluate states. A sample that completes a group runs the
// bit-serial averaging divider, one quotient bit per cycle over the sum width
// (14 bits at MAX_AVG = 16), before any resulting burst reaches the output register.
// A start that opens without a top sensor goes from evaluate to emit.
// The output register frees the input side: a new word is taken while a
// result still waits; if a second result is ready before the first is taken,
// the block holds it and stops accepting until m_axis_tready drains the
// register. Reset (synchronous, active low) restores the default registers,
// marks the blind closed and idle, and empties the output register.
`default_nettype none

module blind_motor_limit_controller_unit #(
    parameter int WINDOW_LEN = 3,
    parameter int MAX_AVG    = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [bmlc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bmlc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // sample[9:0], learn_steps[10], progressive[11], zero[15:12]
    input  wire logic [bmlc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // cmd[0]
    input  wire logic [0:0]                         s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // burst_steps[23:0], direction[24], now_open[25], zero[31:26]
    output logic [bmlc_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // speed_class[0]
    output logic [0:0]                              m_axis_tuser,
    output logic                                    m_axis_tlast
);

    bmlc_pkg::t_dp_cmd  dp_cmd;
    bmlc_pkg::t_dp_stat dp_stat;

    bmlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    bmlc_datapath #(
        .WINDOW_LEN (WINDOW_LEN),
        .MAX_AVG    (MAX_AVG)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_tdata  (s_axis_tdata),
        .i_in_tuser  (s_axis_tuser[0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_tdata (m_axis_tdata),
        .o_out_tuser (m_axis_tuser[0]),
        .o_out_tlast (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/bmlc_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module bmlc_div #(
    parameter int DIVIDEND_W = 14,
    parameter int DIVISOR_W  = 5,
    parameter int QUOT_W     = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [QUOT_W-1:0]          o_quot
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DIVISOR_W:0]    n_trial;
    logic                  n_ge;
    logic [DIVISOR_W-1:0]  n_rem;

    always_comb begin
        n_trial = {r_rem, r_quo[DIVIDEND_W-1]};
        n_ge    = n_trial >= {1'b0, r_div};
        n_rem   = n_ge ? DIVISOR_W'(n_trial - {1'b0, r_div}) : DIVISOR_W'(n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], n_ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo[QUOT_W-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/bmlc_datapath.sv -----
// Datapath: configuration, move state, averaging, window and result registers.
`default_nettype none

module bmlc_datapath #(
    parameter int WINDOW_LEN = 3,
    parameter int MAX_AVG    = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire bmlc_pkg::t_dp_cmd                  i_cmd,
    output bmlc_pkg::t_dp_stat                      o_stat,
    input  wire logic                               i_cfg_we,
    input  wire logic [bmlc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bmlc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic [bmlc_pkg::IN_DATA_W-1:0]     i_in_tdata,
    input  wire logic                               i_in_tuser,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [bmlc_pkg::OUT_DATA_W-1:0]         o_out_tdata,
    output logic                                    o_out_tuser,
    output logic                                    o_out_tlast
);

    localparam int SW      = bmlc_pkg::SAMPLE_W;
    localparam int SUM_W   = $clog2(MAX_AVG * ((1 << SW) - 1) + 1);
    localparam int TALLY_W = $clog2(MAX_AVG + 1);
    localparam int PRE_W   = $clog2(WINDOW_LEN + 1);
    localparam int STD_W   = bmlc_pkg::CNT16_W;
    localparam int CUT_W   = STD_W + $clog2(WINDOW_LEN + 1);
    localparam int ST_W    = bmlc_pkg::STEPS_W;
    localparam int AW      = bmlc_pkg::AVG_W;

    // configuration
    logic [STD_W-1:0] r_std;
    logic [STD_W-1:0] r_fin;
    logic [SW-1:0]    r_bthr;
    logic [SW-1:0]    r_tthr;
    logic [SW-1:0]    r_bmar;
    logic [SW-1:0]    r_tmar;
    logic             r_top_present;
    logic [AW-1:0]    r_avg_cnt;

    // move state
    logic               r_is_open;
    logic               r_moving;
    logic               r_closing;
    logic               r_prog;
    logic               r_learn;
    logic [SUM_W-1:0]   r_sum;
    logic [TALLY_W-1:0] r_tally;
    logic [SW-1:0]      r_window [WINDOW_LEN];
    logic [PRE_W-1:0]   r_preload;
    logic [ST_W-1:0]    r_total;
    logic [ST_W-1:0]    r_learned;

    // latched input word
    logic          r_in_cmd;
    logic [SW-1:0] r_in_sample;
    logic          r_in_learn;
    logic          r_in_prog;

    // staged result
    logic [ST_W-1:0] r_res_steps;
    logic            r_res_dir;
    logic            r_res_speed;
    logic            r_res_last;
    logic            r_res_open;

    // output register
    logic            r_out_valid;
    logic [ST_W-1:0] r_out_steps;
    logic            r_out_dir;
    logic            r_out_speed;
    logic            r_out_last;
    logic            r_out_open;

    logic [TALLY_W-1:0] n_avg_n;
    logic [SUM_W-1:0]   n_sum;
    logic [TALLY_W:0]   n_tally;
    logic               n_grp_full;
    logic               div_start;
    logic               div_done;
    logic [SW-1:0]      avg;
    logic [SW-1:0]      win_sh [WINDOW_LEN];
    logic signed [SW:0] lim;
    logic               all_hit;
    logic               preload_fill;
    logic               go_on;
    logic [CUT_W-1:0]   cut;
    logic [STD_W-1:0]   fin_burst;
    logic [ST_W:0]      sum_std;
    logic [ST_W:0]      sum_fin;
    logic [ST_W-1:0]    n_total_std;
    logic [ST_W-1:0]    n_total_fin;
    logic               out_free;

    always_comb begin
        if (r_avg_cnt == '0) begin
            n_avg_n = TALLY_W'(1);
        end else if (int'(r_avg_cnt) > MAX_AVG) begin
            n_avg_n = TALLY_W'(MAX_AVG);
        end else begin
            n_avg_n = TALLY_W'(r_avg_cnt);
        end
        n_sum      = r_sum + SUM_W'(r_in_sample);
        n_tally    = {1'b0, r_tally} + 1'b1;
        n_grp_full = n_tally >= {1'b0, n_avg_n};
    end

    assign div_start = i_cmd.accum && n_grp_full;

    bmlc_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (TALLY_W),
        .QUOT_W     (SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_avg_n),
        .o_done     (div_done),
        .o_quot     (avg)
    );

    // window after shifting in the new measurement, newest first
    always_comb begin
        win_sh[0] = avg;
        for (int i = 1; i < WINDOW_LEN; i++) begin
            win_sh[i] = r_window[i-1];
        end
        lim = r_closing ? $signed({1'b0, r_bthr}) - $signed({1'b0, r_bmar})
                        : $signed({1'b0, r_tthr}) - $signed({1'b0, r_tmar});
        all_hit = 1'b1;
        for (int i = 0; i < WINDOW_LEN; i++) begin
            if (r_closing) begin
                all_hit = all_hit && ($signed({1'b0, win_sh[i]}) < lim);
            end else begin
                all_hit = all_hit && ($signed({1'b0, win_sh[i]}) > lim);
            end
        end
        preload_fill = r_prog && (r_preload < PRE_W'(WINDOW_LEN));
        if (r_prog) begin
            go_on = !all_hit;
        end else begin
            go_on = r_closing ? (avg > r_bthr) : (avg < r_tthr);
        end
    end

    always_comb begin
        cut = CUT_W'(WINDOW_LEN) * CUT_W'(r_std);
        if (!r_prog) begin
            fin_burst = r_fin;
        end else if (CUT_W'(r_fin) > cut) begin
            fin_burst = STD_W'(CUT_W'(r_fin) - cut);
        end else begin
            fin_burst = '0;
        end
        sum_std     = {1'b0, r_total} + (ST_W + 1)'(r_std);
        sum_fin     = {1'b0, r_total} + (ST_W + 1)'(r_fin);
        n_total_std = sum_std[ST_W] ? {ST_W{1'b1}} : sum_std[ST_W-1:0];
        n_total_fin = sum_fin[ST_W] ? {ST_W{1'b1}} : sum_fin[ST_W-1:0];
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.cmd_is_start = (r_in_cmd == bmlc_pkg::CMD_START);
        o_stat.moving       = r_moving;
        o_stat.start_emits  = !r_is_open && !r_top_present;
        o_stat.sample_ok    = r_moving && (r_in_sample != '0);
        o_stat.grp_full     = n_grp_full;
        o_stat.div_done     = div_done;
        o_stat.meas_emits   = !preload_fill;
        o_stat.out_free     = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_std         <= STD_W'(100);
            r_fin         <= STD_W'(200);
            r_bthr        <= SW'(512);
            r_tthr        <= SW'(512);
            r_bmar        <= '0;
            r_tmar        <= '0;
            r_top_present <= 1'b0;
            r_avg_cnt     <= AW'(4);
            r_is_open     <= 1'b0;
            r_moving      <= 1'b0;
            r_closing     <= 1'b0;
            r_prog        <= 1'b0;
            r_learn       <= 1'b0;
            r_sum         <= '0;
            r_tally       <= '0;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_window[i] <= '0;
            end
            r_preload     <= '0;
            r_total       <= '0;
            r_learned     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bmlc_pkg::REG_STANDARD_STEPS: r_std         <= i_cfg_data;
                    bmlc_pkg::REG_FINAL_STEPS:    r_fin         <= i_cfg_data;
                    bmlc_pkg::REG_BOTTOM_THR:     r_bthr        <= i_cfg_data[SW-1:0];
                    bmlc_pkg::REG_TOP_THR:        r_tthr        <= i_cfg_data[SW-1:0];
                    bmlc_pkg::REG_BOTTOM_MARGIN:  r_bmar        <= i_cfg_data[SW-1:0];
                    bmlc_pkg::REG_TOP_MARGIN:     r_tmar        <= i_cfg_data[SW-1:0];
                    bmlc_pkg::REG_TOP_PRESENT:    r_top_present <= i_cfg_data[0];
                    bmlc_pkg::REG_AVG_COUNT:      r_avg_cnt     <= i_cfg_data[AW-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.start) begin
                r_learn   <= r_in_learn;
                r_prog    <= r_in_prog;
                r_sum     <= '0;
                r_tally   <= '0;
                r_preload <= '0;
                r_total   <= '0;
                if (r_is_open) begin
                    r_closing <= 1'b1;
                    r_moving  <= 1'b1;
                end else begin
                    r_closing <= 1'b0;
                    if (!r_top_present) begin
                        r_is_open <= 1'b1;
                    end else begin
                        r_moving <= 1'b1;
                    end
                end
            end

            if (i_cmd.accum) begin
                if (n_grp_full) begin
                    r_sum   <= '0;
                    r_tally <= '0;
                end else begin
                    r_sum   <= n_sum;
                    r_tally <= n_tally[TALLY_W-1:0];
                end
            end

            if (i_cmd.meas) begin
                if (preload_fill) begin
                    for (int i = 0; i < WINDOW_LEN; i++) begin
                        if (r_preload == PRE_W'(i)) begin
                            r_window[i] <= avg;
                        end
                    end
                    r_preload <= r_preload + 1'b1;
                end else begin
                    if (r_prog) begin
                        for (int i = 0; i < WINDOW_LEN; i++) begin
                            r_window[i] <= win_sh[i];
                        end
                    end
                    if (go_on) begin
                        if (r_closing && r_learn) begin
                            r_total <= n_total_std;
                        end
                    end else begin
                        if (r_closing && r_learn) begin
                            r_total   <= n_total_fin;
                            r_learned <= n_total_fin;
                        end
                        r_is_open <= !r_closing;
                        r_moving  <= 1'b0;
                    end
                end
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: input word, staged result, output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_in_cmd    <= i_in_tuser;
            r_in_sample <= i_in_tdata[SW-1:0];
            r_in_learn  <= i_in_tdata[SW];
            r_in_prog   <= i_in_tdata[SW+1];
        end
        if (i_cmd.start) begin
            r_res_steps <= r_learned;
            r_res_dir   <= 1'b0;
            r_res_speed <= 1'b0;
            r_res_last  <= 1'b1;
            r_res_open  <= 1'b1;
        end
        if (i_cmd.meas) begin
            r_res_dir <= r_closing;
            if (go_on) begin
                r_res_steps <= ST_W'(r_std);
                r_res_speed <= 1'b0;
                r_res_last  <= 1'b0;
                r_res_open  <= r_is_open;
            end else begin
                r_res_steps <= ST_W'(fin_burst);
                r_res_speed <= 1'b1;
                r_res_last  <= 1'b1;
                r_res_open  <= !r_closing;
            end
        end
        if (i_cmd.out_load) begin
            r_out_steps <= r_res_steps;
            r_out_dir   <= r_res_dir;
            r_out_speed <= r_res_speed;
            r_out_last  <= r_res_last;
            r_out_open  <= r_res_open;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_tdata = {(bmlc_pkg::OUT_DATA_W - ST_W - 2)'(0), r_out_open, r_out_dir,
                          r_out_steps};
    assign o_out_tuser = r_out_speed;
    assign o_out_tlast = r_out_last;

endmodule

`default_nettype wire

// ----- hw/rtl/bmlc_ctrl.sv -----
// Controller state machine: sequences one input word through the datapath.
`default_nettype none

`include "blind_motor_limit_controller_unit_macros.svh"

module bmlc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire bmlc_pkg::t_dp_stat i_stat,
    output bmlc_pkg::t_dp_cmd       o_cmd
);

    bmlc_pkg::t_state r_state;
    bmlc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmlc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bmlc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = bmlc_pkg::S_EVAL;
                end
            end
            bmlc_pkg::S_EVAL: begin
                if (i_stat.cmd_is_start) begin
                    if (!i_stat.moving && i_stat.start_emits) begin
                        n_state = bmlc_pkg::S_EMIT;
                    end else begin
                        n_state = bmlc_pkg::S_IDLE;
                    end
                end else if (i_stat.sample_ok && i_stat.grp_full) begin
                    n_state = bmlc_pkg::S_DIV;
                end else begin
                    n_state = bmlc_pkg::S_IDLE;
                end
            end
            bmlc_pkg::S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = bmlc_pkg::S_MEAS;
                end
            end
            bmlc_pkg::S_MEAS: begin
                n_state = i_stat.meas_emits ? bmlc_pkg::S_EMIT : bmlc_pkg::S_IDLE;
            end
            bmlc_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = bmlc_pkg::S_IDLE;
                end
            end
            default: n_state = bmlc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.in_load  = 1'b0;
        o_cmd.start    = 1'b0;
        o_cmd.accum    = 1'b0;
        o_cmd.meas     = 1'b0;
        o_cmd.out_load = 1'b0;
        case (r_state)
            bmlc_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.in_load = i_in_valid;
            end
            bmlc_pkg::S_EVAL: begin
                o_cmd.start = i_stat.cmd_is_start && !i_stat.moving;
                o_cmd.accum = !i_stat.cmd_is_start && i_stat.sample_ok;
            end
            bmlc_pkg::S_MEAS: begin
                o_cmd.meas = 1'b1;
            end
            bmlc_pkg::S_EMIT: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: ;
        endcase
    end

    `BMLC_ASSERT_NEXT(a_accept_to_eval, i_in_valid && o_in_ready, r_state == bmlc_pkg::S_EVAL, "accepted word not evaluated")
    `BMLC_ASSERT_NOW(a_div_done_in_div, i_stat.div_done, r_state == bmlc_pkg::S_DIV, "divider finished outside divide state")
    `BMLC_ASSERT_NOW(a_div_while_moving, r_state == bmlc_pkg::S_DIV, i_stat.moving, "averaging while no move is in progress")
    `BMLC_ASSERT_NEXT(a_meas_after_div, r_state == bmlc_pkg::S_DIV && i_stat.div_done, o_cmd.meas, "measurement not applied after divide")

endmodule

`default_nettype wire

// ----- test/blind_motor_limit_controller_unit_checker.sv -----
// Checker for the blind controller: predicts each step burst and compares the output stream.
module blind_motor_limit_controller_unit_checker #(
    parameter int WINDOW_LEN = 3,
    parameter int MAX_AVG    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bmlc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bmlc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    // sample[9:0], learn_steps[10], progressive[11], zero[15:12]
    input  logic [bmlc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // cmd[0]
    input  logic [0:0]                          s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // burst_steps[23:0], direction[24], now_open[25], zero[31:26]
    input  logic [bmlc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // speed_class[0]
    input  logic [0:0]                          m_axis_tuser,
    input  logic                                m_axis_tlast,
    output int                                  o_errors,
    output int                                  o_pending,
    output logic                                o_open
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [23:0] steps;
        logic        closing;
        logic        slow;
        logic        ends;
        logic        opened;
    } t_burst;

    t_burst pending_bursts[$];
    int     err_count = 0;

    // register copies
    logic [15:0] std_steps, fin_steps;
    logic [9:0]  bot_thr, top_thr, bot_margin, top_margin;
    logic        top_present;
    logic [4:0]  avg_cfg;

    // blind state
    logic        is_open, moving, closing, prog_mode, learn_mode;
    logic [13:0] acc_sum;
    logic [4:0]  acc_tally;
    logic [9:0]  win [WINDOW_LEN];
    logic [1:0]  fill;
    logic [23:0] run_total, full_travel;

    function automatic void clear_blind();
        std_steps   = 16'd100;
        fin_steps   = 16'd200;
        bot_thr     = 10'd512;
        top_thr     = 10'd512;
        bot_margin  = '0;
        top_margin  = '0;
        top_present = 1'b0;
        avg_cfg     = 5'd4;
        is_open     = 1'b0;
        moving      = 1'b0;
        closing     = 1'b0;
        prog_mode   = 1'b0;
        learn_mode  = 1'b0;
        acc_sum     = '0;
        acc_tally   = '0;
        for (int i = 0; i < WINDOW_LEN; i++) win[i] = '0;
        fill        = '0;
        run_total   = '0;
        full_travel = '0;
    endfunction

    function automatic void write_setting(logic [bmlc_pkg::CFG_IDX_W-1:0] idx,
                                          logic [bmlc_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            bmlc_pkg::REG_STANDARD_STEPS: std_steps   = val;
            bmlc_pkg::REG_FINAL_STEPS:    fin_steps   = val;
            bmlc_pkg::REG_BOTTOM_THR:     bot_thr     = val[9:0];
            bmlc_pkg::REG_TOP_THR:        top_thr     = val[9:0];
            bmlc_pkg::REG_BOTTOM_MARGIN:  bot_margin  = val[9:0];
            bmlc_pkg::REG_TOP_MARGIN:     top_margin  = val[9:0];
            bmlc_pkg::REG_TOP_PRESENT:    top_present = val[0];
            bmlc_pkg::REG_AVG_COUNT:      avg_cfg     = val[4:0];
            default: ;
        endcase
    endfunction

    function automatic void queue_burst(logic [23:0] steps, logic slow, logic ends);
        t_burst b;
        b.steps   = steps;
        b.closing = closing;
        b.slow    = slow;
        b.ends    = ends;
        b.opened  = is_open;
        pending_bursts.push_back(b);
    endfunction

    // saturate the learned travel at 24 bits
    function automatic void add_travel(int n);
        int t;
        t = int'(run_total) + n;
        run_total = (t > 'hFFFFFF) ? 24'hFFFFFF : 24'(t);
    endfunction

    function automatic void predict_word(logic cmd, logic [9:0] smp, logic learn, logic prog);
        int          n;
        int          lim;
        int          hits;
        int          cut;
        logic [9:0]  meas;
        logic        keep_going;
        logic [23:0] fin;
        if (cmd == bmlc_pkg::CMD_START) begin
            if (moving) return;
            learn_mode = learn;
            prog_mode  = prog;
            acc_sum    = '0;
            acc_tally  = '0;
            fill       = '0;
            run_total  = '0;
            if (is_open) begin
                closing = 1'b1;
                moving  = 1'b1;
            end else begin
                closing = 1'b0;
                if (!top_present) begin
                    // no top sensor: open in one go by the learned travel
                    is_open = 1'b1;
                    queue_burst(full_travel, 1'b0, 1'b1);
                end else begin
                    moving = 1'b1;
                end
            end
            return;
        end
        if (!moving || smp == 10'd0) return;
        n = int'(avg_cfg);
        if (n < 1) n = 1;
        if (n > MAX_AVG) n = MAX_AVG;
        acc_sum   = acc_sum + smp;
        acc_tally = acc_tally + 5'd1;
        if (int'(acc_tally) < n) return;
        meas      = 10'(int'(acc_sum) / n);
        acc_sum   = '0;
        acc_tally = '0;
        if (prog_mode) begin
            if (int'(fill) < WINDOW_LEN) begin
                win[fill] = meas;
                fill      = fill + 2'd1;
                return;
            end
            for (int i = WINDOW_LEN - 1; i > 0; i--) win[i] = win[i-1];
            win[0] = meas;
            lim = closing ? int'(bot_thr) - int'(bot_margin) : int'(top_thr) - int'(top_margin);
            hits = 0;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                if (closing ? (int'(win[i]) < lim) : (int'(win[i]) > lim)) hits++;
            end
            keep_going = (hits != WINDOW_LEN);
        end else begin
            keep_going = closing ? (meas > bot_thr) : (meas < top_thr);
        end
        if (keep_going) begin
            if (closing && learn_mode) add_travel(int'(std_steps));
            queue_burst(24'(std_steps), 1'b0, 1'b0);
            return;
        end
        fin = 24'(fin_steps);
        if (prog_mode) begin
            cut = WINDOW_LEN * int'(std_steps);
            fin = (int'(fin_steps) > cut) ? 24'(int'(fin_steps) - cut) : 24'd0;
        end
        if (closing && learn_mode) begin
            add_travel(int'(fin_steps));
            full_travel = run_total;
        end
        is_open = !closing;
        moving  = 1'b0;
        queue_burst(fin, 1'b1, 1'b1);
    endfunction

    function automatic void check_burst();
        t_burst got;
        t_burst want;
        got.steps   = m_axis_tdata[23:0];
        got.closing = m_axis_tdata[24];
        got.opened  = m_axis_tdata[25];
        got.slow    = m_axis_tuser[0];
        got.ends    = m_axis_tlast;
        if (pending_bursts.size() == 0) begin
            err_count++;
            if (err_count <= 10)
                $display("unexpected burst: steps=%0d dir=%0b speed=%0b last=%0b open=%0b",
                         got.steps, got.closing, got.slow, got.ends, got.opened);
            return;
        end
        want = pending_bursts.pop_front();
        if (got !== want) begin
            err_count++;
            if (err_count <= 10)
                $display({"burst mismatch: expected steps=%0d dir=%0b speed=%0b last=%0b open=%0b,",
                          " got steps=%0d dir=%0b speed=%0b last=%0b open=%0b"},
                         want.steps, want.closing, want.slow, want.ends, want.opened,
                         got.steps, got.closing, got.slow, got.ends, got.opened);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_blind();
            pending_bursts.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_burst();
            if (i_cfg_we) write_setting(i_cfg_idx, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                predict_word(s_axis_tuser[0], s_axis_tdata[9:0], s_axis_tdata[10], s_axis_tdata[11]);
        end
        o_errors  <= err_count;
        o_pending <= pending_bursts.size();
        o_open    <= is_open;
    end

endmodule

// ----- test/blind_motor_limit_controller_unit_test.sv -----
// Testbench top for the blind controller: stimulus, flow control and verdict.
module blind_motor_limit_controller_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 130;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int MAX_AVG_SAMPLES = 16;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [bmlc_pkg::CFG_IDX_W-1:0]   cfg_idx;
    logic [bmlc_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             s_valid;
    logic                             s_ready;
    logic [bmlc_pkg::IN_DATA_W-1:0]   s_data;
    logic [0:0]                       s_user;
    logic                             m_valid;
    logic                             m_ready;
    logic [bmlc_pkg::OUT_DATA_W-1:0]  m_data;
    logic [0:0]                       m_user;
    logic                             m_last;
    int                               fail_count;
    int                               bursts_due;
    logic                             blind_open;

    // flow-control knobs and copies of the thresholds
    logic                   quiet = 1'b0;
    int                     gap_pct = 20;
    logic [9:0]             cur_bthr = 10'd512;
    logic [9:0]             cur_tthr = 10'd512;

    blind_motor_limit_controller_unit i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last)
    );

    blind_motor_limit_controller_unit_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last),
        .o_errors      (fail_count),
        .o_pending     (bursts_due),
        .o_open        (blind_open)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // burst receiver: random stalls, always ready once quiet
    initial begin
        m_ready = 1'b0;
        forever begin
            m_ready = 1'b1;
            if (quiet) begin
                @(negedge clk);
            end else begin
                repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12))
                    @(negedge clk);
                if (!quiet) begin
                    m_ready = 1'b0;
                    repeat ($urandom_range(1, 11)) @(negedge clk);
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // All tasks start and end on a falling edge.
    task automatic set_reg(logic [bmlc_pkg::CFG_IDX_W-1:0] idx, int val);
        cfg_idx  = idx;
        cfg_data = bmlc_pkg::CFG_DATA_W'(val);
        cfg_we   = 1'b1;
        if (idx == bmlc_pkg::REG_BOTTOM_THR) cur_bthr = 10'(val);
        if (idx == bmlc_pkg::REG_TOP_THR) cur_tthr = 10'(val);
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    task automatic load_setting(int std, int fin, int bthr, int tthr, int bm, int tm,
                                int present, int avg);
        set_reg(bmlc_pkg::REG_STANDARD_STEPS, std);
        set_reg(bmlc_pkg::REG_FINAL_STEPS, fin);
        set_reg(bmlc_pkg::REG_BOTTOM_THR, bthr);
        set_reg(bmlc_pkg::REG_TOP_THR, tthr);
        set_reg(bmlc_pkg::REG_BOTTOM_MARGIN, bm);
        set_reg(bmlc_pkg::REG_TOP_MARGIN, tm);
        set_reg(bmlc_pkg::REG_TOP_PRESENT, present);
        set_reg(bmlc_pkg::REG_AVG_COUNT, avg);
    endtask

    task automatic feed_word(logic cmd, logic [9:0] smp, logic learn, logic prog);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_valid = 1'b1;
        s_user  = cmd;
        s_data  = {4'b0, prog, learn, smp};
        do @(posedge clk); while (!s_ready);
        @(negedge clk);
    endtask

    // hold the input until every burst is out and the block has gone quiet
    task automatic settle();
        s_valid = 1'b0;
        while (bursts_due != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // force any move in progress to finish so registers can change cleanly
    task automatic park_blind();
        settle();
        set_reg(bmlc_pkg::REG_BOTTOM_THR, 1023);
        set_reg(bmlc_pkg::REG_BOTTOM_MARGIN, 0);
        set_reg(bmlc_pkg::REG_TOP_THR, 0);
        set_reg(bmlc_pkg::REG_TOP_MARGIN, 0);
        repeat (4 * MAX_AVG_SAMPLES) feed_word(bmlc_pkg::CMD_SAMPLE, 10'd1,
                                               1'($urandom_range(0, 1)),
                                               1'($urandom_range(0, 1)));
        settle();
    endtask

    function automatic logic [9:0] pick_sample();
        int r;
        int v;
        r = $urandom_range(0, 99);
        v = ($urandom_range(0, 1) != 0) ? int'(cur_bthr) : int'(cur_tthr);
        if (r < 6) return 10'd0;
        if (r < 12) return 10'd1023;
        if (r < 16) return 10'd1;
        if (r < 60) begin
            v = v + int'($urandom_range(0, 120)) - 60;
            if (v < 1) v = 1;
            if (v > 1023) v = 1023;
            return 10'(v);
        end
        return 10'($urandom_range(1, 1023));
    endfunction

    // mostly start-then-samples moves, with some stray words mixed in
    task automatic run_moves(int budget);
        int left;
        int len;
        left = budget;
        while (left > 0) begin
            if ($urandom_range(0, 99) < 12) begin
                feed_word(($urandom_range(0, 1) != 0) ? bmlc_pkg::CMD_SAMPLE : bmlc_pkg::CMD_START,
                          10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                left--;
            end else begin
                feed_word(bmlc_pkg::CMD_START, 10'($urandom_range(0, 1023)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                left--;
                len = $urandom_range(1, 48);
                repeat (len) begin
                    feed_word(bmlc_pkg::CMD_SAMPLE, pick_sample(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                    left--;
                end
            end
        end
    endtask

    initial begin
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        s_valid  = 1'b0;
        s_data   = '0;
        s_user   = bmlc_pkg::CMD_START;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: one sample per measurement
        set_reg(bmlc_pkg::REG_AVG_COUNT, 1);
        feed_word(bmlc_pkg::CMD_START, 10'd0, 1'b1, 1'b0);    // open without top sensor
        feed_word(bmlc_pkg::CMD_SAMPLE, 10'd5, 1'b0, 1'b0);   // sample while idle
        feed_word(bmlc_pkg::CMD_START, 10'h3FF, 1'b1, 1'b1);  // progressive learning close
        feed_word(bmlc_pkg::CMD_START, 10'd0, 1'b0, 1'b0);    // start while moving
        feed_word(bmlc_pkg::CMD_SAMPLE, 10'd0, 1'b1, 1'b1);   // zero sample dropped
        repeat (4) feed_word(bmlc_pkg::CMD_SAMPLE, 10'd1023, 1'b0, 1'b0);
        repeat (3) feed_word(bmlc_pkg::CMD_SAMPLE, 10'd1, 1'b0, 1'b0);
        feed_word(bmlc_pkg::CMD_START, 10'd0, 1'b0, 1'b0);    // open by learned travel
        feed_word(bmlc_pkg::CMD_START, 10'd0, 1'b0, 1'b0);    // plain close
        feed_word(bmlc_pkg::CMD_SAMPLE, 10'd513, 1'b0, 1'b0);
        feed_word(bmlc_pkg::CMD_SAMPLE, 10'd512, 1'b0, 1'b0);
        settle();
        set_reg(bmlc_pkg::REG_TOP_PRESENT, 1);
        feed_word(bmlc_pkg::CMD_START, 10'd0, 1'b0, 1'b0);    // sensed plain open
        feed_word(bmlc_pkg::CMD_SAMPLE, 10'd511, 1'b0, 1'b0);
        feed_word(bmlc_pkg::CMD_SAMPLE, 10'd512, 1'b0, 1'b0);
        feed_word(bmlc_pkg::CMD_START, 10'd0, 1'b1, 1'b0);
        feed_word(bmlc_pkg::CMD_SAMPLE, 10'd1, 1'b0, 1'b0);
        feed_word(bmlc_pkg::CMD_START, 10'd0, 1'b0, 1'b1);    // progressive open
        repeat (4) feed_word(bmlc_pkg::CMD_SAMPLE, 10'd1023, 1'b0, 1'b0);

        // learned travel saturates at 24 bits over a long close
        settle();
        load_setting(65535, 65535, 0, 512, 0, 0, 0, 1);
        if (!blind_open) begin
            feed_word(bmlc_pkg::CMD_START, 10'd0, 1'b0, 1'b0);
            settle();
        end
        feed_word(bmlc_pkg::CMD_START, 10'd0, 1'b1, 1'b0);
        repeat (258) feed_word(bmlc_pkg::CMD_SAMPLE, 10'($urandom_range(1, 1023)), 1'b0, 1'b0);
        settle();
        set_reg(bmlc_pkg::REG_BOTTOM_THR, 1023);
        feed_word(bmlc_pkg::CMD_SAMPLE, 10'd1, 1'b0, 1'b0);
        feed_word(bmlc_pkg::CMD_START, 10'd0, 1'b0, 1'b0);

        for (int ph = 0; ph < PHASES; ph++) begin
            park_blind();
            quiet   = (ph == PHASES - 1);
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            case (ph)
                0: load_setting(100, 200, 512, 512, 0, 0, 1, 4);
                1: load_setting(0, 0, 300, 700, 0, 0, 1, 1);
                2: load_setting(65535, 65535, 600, 400, 50, 50, 1, 16);
                3: load_setting(1000, 500, 1023, 0, 1023, 1023, 1, 2);
                4: load_setting(37, 65535, 0, 1023, 0, 0, 0, 0);
                5: load_setting($urandom_range(0, 65535), $urandom_range(0, 65535),
                                $urandom_range(1, 1022), $urandom_range(1, 1022),
                                $urandom_range(0, 200), $urandom_range(0, 200), 1, 31);
                6: load_setting($urandom_range(0, 65535), $urandom_range(0, 65535),
                                $urandom_range(0, 1023), $urandom_range(0, 1023),
                                $urandom_range(0, 1023), $urandom_range(0, 1023),
                                $urandom_range(0, 1), $urandom_range(1, 16));
                default: load_setting($urandom_range(0, 2000), $urandom_range(0, 8000),
                                      $urandom_range(100, 900), $urandom_range(100, 900),
                                      $urandom_range(0, 100), $urandom_range(0, 100), 1, 3);
            endcase
            run_moves(PHASE_ITEMS);
        end

        settle();
        if (fail_count == 0 && bursts_due == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/bmlc_pkg.sv
hw/rtl/bmlc_div.sv
hw/rtl/bmlc_datapath.sv
hw/rtl/bmlc_ctrl.sv
hw/rtl/blind_motor_limit_controller_unit.sv
test/blind_motor_limit_controller_unit_checker.sv
test/blind_motor_limit_controller_unit_test.sv
